FILE: sv/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg: shared types and constants of the MD5 stream hasher
// Sequencer states, the padding progress code and the fixed MD5 tables.
// ----------------------------------------------------------------------------
package md5_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_FOLD,
    S_PAD,
    S_LEN,
    S_OUT
  } state_t;

  // Where the finishing sequence of a message stands.
  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_EXTRA,
    FIN_LAST
  } fin_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0]  PAD_BYTE     = 8'h80;
  localparam logic [5:0]  LAST_POS     = 6'd63;
  localparam logic [5:0]  LAST_ROUND   = 6'd63;
  localparam logic [1:0]  LAST_IDX     = 2'd3;
  localparam logic [2:0]  LEN_ROW      = 3'd7;   // byte positions 56..63
  localparam logic [3:0]  LEN_LO_WORD  = 4'd14;
  localparam logic [3:0]  LEN_HI_WORD  = 4'd15;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Rotate left by 1..31.
  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [5:0] rs;
    rs = 6'd32 - {1'b0, n};
    return (x << n) | (x >> rs);
  endfunction

  // Mask that keeps the bytes below byte lane n of a word.
  function automatic logic [31:0] low_mask(input logic [1:0] n);
    logic [31:0] m;
    case (n)
      2'd0:    m = 32'h0000_0000;
      2'd1:    m = 32'h0000_00ff;
      2'd2:    m = 32'h0000_ffff;
      2'd3:    m = 32'h00ff_ffff;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

FILE: sv/md5_stream_hasher.sv
// ----------------------------------------------------------------------------
// md5_stream_hasher: MD5 digest over a byte stream
// Packs message bytes into a 16-word block, runs the 64-round compression
// through one shared round unit, pads on message end and emits the digest.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   -------  -------------------  ------------------------------------------
//   input    in_valid / in_ready  data_byte, byte_present, message_end
//   output   out_valid/out_ready  digest_word, word_index, last_word
//
// An ordinary byte item is stored in the block buffer. The item with the 64th
// byte of a block also starts a compression: loading the working words, 64
// rounds through the single round unit (one round per cycle), and a fold into
// the chaining words. A message end adds a padding step, a 64-round compression
// and a fold, plus a length block with its own compression and fold when the
// tail held 56 or more bytes, then four digest words. No byte is taken during a
// compression, so the one-round-per-cycle loop sets the rate on long messages.
// Reset (synchronous, active high) loads the standard initial value and clears
// the bit counter; the block buffer is not cleared. in_ready is low from the
// cycle after an item starts a compression or a finish until the last digest
// word is taken; a stalled out_ready simply holds the current digest word.
module md5_stream_hasher
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);

  // Sequencer state.
  state_t      state, state_next;
  fin_t        fin;
  logic        pend_end;
  logic [5:0]  rnd;
  logic [1:0]  idx;

  // Message state.
  logic [63:0] message_bits;
  logic [31:0] chain [4];
  logic [31:0] block [16];

  // Working words of the round unit.
  logic [31:0] wa, wb, wc, wd;

  // Control decoded from the state.
  logic in_acc;
  logic start_round;
  logic out_acc;

  // Byte position of the next free byte in the block.
  logic [5:0] pos;
  assign pos    = message_bits[8:3];
  assign in_acc = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // --------------------------------------------------------------------------
  // Next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (byte_present && pos == LAST_POS) begin
            state_next = S_ROUND;
          end else if (message_end) begin
            state_next = S_PAD;
          end
        end
      end
      S_ROUND: begin
        if (rnd == LAST_ROUND) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        if (!pend_end) begin
          state_next = S_IDLE;
        end else begin
          case (fin)
            FIN_NONE:  state_next = S_PAD;
            FIN_EXTRA: state_next = S_LEN;
            FIN_LAST:  state_next = S_OUT;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_PAD:   state_next = S_ROUND;
      S_LEN:   state_next = S_ROUND;
      S_OUT: begin
        if (out_acc && idx == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs of the sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    start_round = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        start_round = in_acc && byte_present && pos == LAST_POS;
      end
      S_PAD:   start_round = 1'b1;
      S_LEN:   start_round = 1'b1;
      S_OUT:   out_valid   = 1'b1;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign digest_word = chain[idx];
  assign word_index  = idx;
  assign last_word   = (idx == LAST_IDX);

  // --------------------------------------------------------------------------
  // Round unit: one MD5 round per cycle over the working words.
  // --------------------------------------------------------------------------
  logic [1:0]  phase;
  logic [3:0]  g;
  logic [31:0] f;
  logic [31:0] t;
  logic [31:0] nb;

  assign phase = rnd[5:4];

  always_comb begin
    case (phase)
      2'd0: begin
        f = (wb & wc) | (~wb & wd);
        g = rnd[3:0];
      end
      2'd1: begin
        f = (wb & wd) | (wc & ~wd);
        g = rnd[3:0] * 4'd5 + 4'd1;
      end
      2'd2: begin
        f = wb ^ wc ^ wd;
        g = rnd[3:0] * 4'd3 + 4'd5;
      end
      default: begin
        f = wc ^ (wb | ~wd);
        g = rnd[3:0] * 4'd7;
      end
    endcase
    t  = wa + f + block[g] + ROUND_K[rnd];
    nb = wb + rotl32(t, ROT_AMT[{phase, rnd[1:0]}]);
  end

  // --------------------------------------------------------------------------
  // Padding of the last block: 0x80 at the next free byte, zeros after it,
  // and the length in the top two words when they are free.
  // --------------------------------------------------------------------------
  logic [31:0] pad_word [16];
  logic        len_fits;

  assign len_fits = (pos[5:3] != LEN_ROW);

  always_comb begin
    for (int w = 0; w < 16; w++) begin
      if (4'(w) > pos[5:2]) begin
        pad_word[w] = 32'h0;
      end else if (4'(w) == pos[5:2]) begin
        pad_word[w] = (block[w] & low_mask(pos[1:0]))
                    | ({24'h0, PAD_BYTE} << {pos[1:0], 3'b000});
      end else begin
        pad_word[w] = block[w];
      end
    end
    if (len_fits) begin
      pad_word[LEN_LO_WORD] = message_bits[31:0];
      pad_word[LEN_HI_WORD] = message_bits[63:32];
    end
  end

  // --------------------------------------------------------------------------
  // Control registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fin          <= FIN_NONE;
      pend_end     <= 1'b0;
      rnd          <= '0;
      idx          <= '0;
      message_bits <= '0;
      chain[0]     <= INIT_A;
      chain[1]     <= INIT_B;
      chain[2]     <= INIT_C;
      chain[3]     <= INIT_D;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            pend_end <= message_end;
            fin      <= FIN_NONE;
            if (byte_present) begin
              message_bits <= message_bits + 64'd8;
            end
          end
        end
        S_ROUND: rnd <= rnd + 6'd1;
        S_FOLD: begin
          chain[0] <= chain[0] + wa;
          chain[1] <= chain[1] + wb;
          chain[2] <= chain[2] + wc;
          chain[3] <= chain[3] + wd;
        end
        S_PAD:   fin <= len_fits ? FIN_LAST : FIN_EXTRA;
        S_LEN:   fin <= FIN_LAST;
        S_OUT: begin
          if (out_acc) begin
            idx <= idx + 2'd1;
            if (idx == LAST_IDX) begin
              pend_end     <= 1'b0;
              fin          <= FIN_NONE;
              message_bits <= '0;
              chain[0]     <= INIT_A;
              chain[1]     <= INIT_B;
              chain[2]     <= INIT_C;
              chain[3]     <= INIT_D;
            end
          end
        end
        default: begin
          rnd <= '0;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers: block buffer and working words.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc && byte_present) begin
          block[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= data_byte;
        end
      end
      S_PAD: begin
        for (int w = 0; w < 16; w++) begin
          block[w] <= pad_word[w];
        end
      end
      S_LEN: begin
        for (int w = 0; w < 16; w++) begin
          if (4'(w) == LEN_LO_WORD) begin
            block[w] <= message_bits[31:0];
          end else if (4'(w) == LEN_HI_WORD) begin
            block[w] <= message_bits[63:32];
          end else begin
            block[w] <= 32'h0;
          end
        end
      end
      default: begin
        block[0] <= block[0];
      end
    endcase

    if (start_round) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
    end else if (state == S_ROUND) begin
      wa <= wd;
      wb <= nb;
      wc <= wb;
      wd <= wc;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_ready_vs_out: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a digest word is offered");

  a_round_count_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_ROUND) |-> (rnd == '0))
    else $error("round counter left running outside the round loop");

  a_out_only_final: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fin == FIN_LAST && pend_end))
    else $error("digest offered before the length block was compressed");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_acc && last_word) |=> (in_ready && message_bits == '0))
    else $error("block did not return to idle after the last digest word");

  a_len_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && $past(state) == S_ROUND) |-> $stable(message_bits))
    else $error("bit counter changed during compression");

endmodule
